FILE: rtl/bpp_pkg.sv
// bpp_pkg: shared constants, register indexes and defaults for the boris particle pusher
// no dependencies; imported by bpp_cross and the top level
package bpp_pkg;

  // data format defaults (signed q16.16)
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // rotation and shear vectors are signed q2.30
  localparam int ROT_W    = 32;
  localparam int ROT_FRAC = 30;

  localparam int REG_ADDR_W = 3;

  typedef enum logic [REG_ADDR_W-1:0] {
    REG_ROT_X      = 3'd0,
    REG_ROT_Y      = 3'd1,
    REG_ROT_Z      = 3'd2,
    REG_SHEAR_X    = 3'd3,
    REG_SHEAR_Y    = 3'd4,
    REG_SHEAR_Z    = 3'd5,
    REG_KICK_SCALE = 3'd6,
    REG_TIME_STEP  = 3'd7
  } reg_idx_t;

endpackage

FILE: rtl/bpp_kick.sv
// bpp_kick: two-stage half electric kick, ef = kick*E and vm = v + ef, both saturated
// standalone module, no package dependency
module bpp_kick #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [DATA_WIDTH-1:0] pos_i   [2],
  input  logic signed [DATA_WIDTH-1:0] vel_i   [3],
  input  logic signed [DATA_WIDTH-1:0] field_i [2],
  input  logic signed [DATA_WIDTH-1:0] kick_i,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [DATA_WIDTH-1:0] pos_o   [2],
  output logic signed [DATA_WIDTH-1:0] vm_o    [3],
  output logic signed [DATA_WIDTH-1:0] ef_o    [3]
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = PW + 1;
  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [DATA_WIDTH-1:0] r;
    if (x > SMAX) begin
      r = DMAX;
    end else if (x < SMIN) begin
      r = DMIN;
    end else begin
      r = x[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  logic                         a_vld_r;
  logic signed [DATA_WIDTH-1:0] a_pos_r  [2];
  logic signed [DATA_WIDTH-1:0] a_vel_r  [3];
  logic signed [PW-1:0]         a_prod_r [2];
  logic                         b_vld_r;
  logic signed [DATA_WIDTH-1:0] b_pos_r  [2];
  logic signed [DATA_WIDTH-1:0] b_vm_r   [3];
  logic signed [DATA_WIDTH-1:0] b_ef_r   [3];
  logic signed [DATA_WIDTH-1:0] ef_nxt   [3];
  logic signed [DATA_WIDTH-1:0] vm_nxt   [3];
  logic                         a_rdy;
  logic                         b_rdy;

  assign b_rdy    = !b_vld_r || dn_ready;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign up_ready = a_rdy;

  // field has no z component, so ef.z is zero and vm.z is v.z
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ef_nxt[i] = sat(SW'(a_prod_r[i] >>> FRAC_BITS));
      vm_nxt[i] = sat(SW'(a_vel_r[i]) + SW'(ef_nxt[i]));
    end
    ef_nxt[2] = '0;
    vm_nxt[2] = a_vel_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= up_valid;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && a_rdy) begin
      a_pos_r <= pos_i;
      a_vel_r <= vel_i;
      for (int i = 0; i < 2; i++) begin
        a_prod_r[i] <= PW'(kick_i) * PW'(field_i[i]);
      end
    end
    if (a_vld_r && b_rdy) begin
      b_pos_r <= a_pos_r;
      b_vm_r  <= vm_nxt;
      b_ef_r  <= ef_nxt;
    end
  end

  assign dn_valid = b_vld_r;
  assign pos_o    = b_pos_r;
  assign vm_o     = b_vm_r;
  assign ef_o     = b_ef_r;

endmodule

FILE: rtl/bpp_cross.sv
// bpp_cross: two-stage cross product unit, res = sat(base + sat((a x b) >> 30) + extra)
// depends on bpp_pkg for the q2.30 vector format
module bpp_cross #(
  parameter int DATA_WIDTH = 32,
  parameter int CARRY_W    = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [DATA_WIDTH-1:0] a_i     [3],
  input  logic signed [bpp_pkg::ROT_W-1:0] b_i [3],
  input  logic signed [DATA_WIDTH-1:0] base_i  [3],
  input  logic signed [DATA_WIDTH-1:0] extra_i [3],
  input  logic [CARRY_W-1:0]           carry_i,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [DATA_WIDTH-1:0] res_o   [3],
  output logic [CARRY_W-1:0]           carry_o
);

  import bpp_pkg::*;

  localparam int PW = DATA_WIDTH + ROT_W;
  localparam int SW = PW + 1;
  localparam int QW = DATA_WIDTH + 2;
  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [DATA_WIDTH-1:0] r;
    if (x > SMAX) begin
      r = DMAX;
    end else if (x < SMIN) begin
      r = DMIN;
    end else begin
      r = x[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  logic                         a_vld_r;
  logic signed [PW-1:0]         a_pj_r    [3];
  logic signed [PW-1:0]         a_pk_r    [3];
  logic signed [DATA_WIDTH-1:0] a_base_r  [3];
  logic signed [DATA_WIDTH-1:0] a_extra_r [3];
  logic [CARRY_W-1:0]           a_carry_r;
  logic                         b_vld_r;
  logic signed [DATA_WIDTH-1:0] b_res_r   [3];
  logic [CARRY_W-1:0]           b_carry_r;
  logic signed [SW-1:0]         diff      [3];
  logic signed [DATA_WIDTH-1:0] cr        [3];
  logic signed [QW-1:0]         sum       [3];
  logic signed [DATA_WIDTH-1:0] res_nxt   [3];
  logic                         a_rdy;
  logic                         b_rdy;

  assign b_rdy    = !b_vld_r || dn_ready;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign up_ready = a_rdy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]    = SW'(a_pj_r[i]) - SW'(a_pk_r[i]);
      cr[i]      = sat(diff[i] >>> ROT_FRAC);
      sum[i]     = QW'(a_base_r[i]) + QW'(cr[i]) + QW'(a_extra_r[i]);
      res_nxt[i] = sat(SW'(sum[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= up_valid;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  // component i takes a[i+1]*b[i+2] - a[i+2]*b[i+1]
  always_ff @(posedge clk) begin
    if (up_valid && a_rdy) begin
      a_pj_r[0] <= PW'(a_i[1]) * PW'(b_i[2]);
      a_pk_r[0] <= PW'(a_i[2]) * PW'(b_i[1]);
      a_pj_r[1] <= PW'(a_i[2]) * PW'(b_i[0]);
      a_pk_r[1] <= PW'(a_i[0]) * PW'(b_i[2]);
      a_pj_r[2] <= PW'(a_i[0]) * PW'(b_i[1]);
      a_pk_r[2] <= PW'(a_i[1]) * PW'(b_i[0]);
      a_base_r  <= base_i;
      a_extra_r <= extra_i;
      a_carry_r <= carry_i;
    end
    if (a_vld_r && b_rdy) begin
      b_res_r   <= res_nxt;
      b_carry_r <= a_carry_r;
    end
  end

  assign dn_valid = b_vld_r;
  assign res_o    = b_res_r;
  assign carry_o  = b_carry_r;

endmodule

FILE: rtl/bpp_advance.sv
// bpp_advance: two-stage position update, p' = sat(p + (dt*v') >> frac), with output registers
// standalone module, no package dependency
module bpp_advance #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [DATA_WIDTH-1:0] pos_i  [2],
  input  logic signed [DATA_WIDTH-1:0] vel_i  [3],
  input  logic [DATA_WIDTH-2:0]        step_i,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [DATA_WIDTH-1:0] pos_o  [2],
  output logic signed [DATA_WIDTH-1:0] vel_o  [3]
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = PW + 1;
  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [DATA_WIDTH-1:0] r;
    if (x > SMAX) begin
      r = DMAX;
    end else if (x < SMIN) begin
      r = DMIN;
    end else begin
      r = x[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  logic                         a_vld_r;
  logic signed [DATA_WIDTH-1:0] a_pos_r  [2];
  logic signed [DATA_WIDTH-1:0] a_vel_r  [3];
  logic signed [PW-1:0]         a_prod_r [2];
  logic                         b_vld_r;
  logic signed [DATA_WIDTH-1:0] b_pos_r  [2];
  logic signed [DATA_WIDTH-1:0] b_vel_r  [3];
  logic signed [DATA_WIDTH-1:0] pos_nxt  [2];
  logic signed [DATA_WIDTH-1:0] step_s;
  logic                         a_rdy;
  logic                         b_rdy;

  assign b_rdy    = !b_vld_r || dn_ready;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign up_ready = a_rdy;

  // time step is unsigned, widen with a zero sign bit
  assign step_s = $signed({1'b0, step_i});

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      pos_nxt[i] = sat(SW'(a_pos_r[i]) + SW'(a_prod_r[i] >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= up_valid;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && a_rdy) begin
      a_pos_r <= pos_i;
      a_vel_r <= vel_i;
      for (int i = 0; i < 2; i++) begin
        a_prod_r[i] <= PW'(step_s) * PW'(vel_i[i]);
      end
    end
    if (a_vld_r && b_rdy) begin
      b_pos_r <= pos_nxt;
      b_vel_r <= a_vel_r;
    end
  end

  assign dn_valid = b_vld_r;
  assign pos_o    = b_pos_r;
  assign vel_o    = b_vel_r;

endmodule

FILE: rtl/boris_particle_push.sv
// One Boris step per particle. The block takes one particle word per clock
// while in_stall is low and returns its result word from an 8-stage
// pipeline of two stages each for the electric kick, the vm x T rotation,
// the (vm + vm x T) x s rotation and the position update; throughput is one
// particle per cycle when nothing stalls. Each stage holds a valid bit and
// stalls only while the next is full and stalled, so bubbles close up and
// a word waiting at the output stops input only once every stage is full.
// Rotation and shear vectors are signed q2.30, the time step unsigned, all
// else signed q(DATA_WIDTH-FRAC_BITS).FRAC_BITS; each unit saturates.
// Load the registers only while the pipeline is empty.
// boris_particle_push: top level with configuration registers
// depends on bpp_pkg, bpp_kick, bpp_cross and bpp_advance
module boris_particle_push #(
  parameter int DATA_WIDTH = bpp_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = bpp_pkg::FRAC_BITS_DEF,
  localparam int CFG_W = (DATA_WIDTH > bpp_pkg::ROT_W) ? DATA_WIDTH : bpp_pkg::ROT_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bpp_pkg::REG_ADDR_W-1:0]    cfg_addr,
  input  logic [CFG_W-1:0]                  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [DATA_WIDTH-1:0]      in_pos_x,
  input  logic signed [DATA_WIDTH-1:0]      in_pos_y,
  input  logic signed [DATA_WIDTH-1:0]      in_vel_x,
  input  logic signed [DATA_WIDTH-1:0]      in_vel_y,
  input  logic signed [DATA_WIDTH-1:0]      in_vel_z,
  input  logic signed [DATA_WIDTH-1:0]      in_field_x,
  input  logic signed [DATA_WIDTH-1:0]      in_field_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_new_pos_x,
  output logic signed [DATA_WIDTH-1:0]      out_new_pos_y,
  output logic signed [DATA_WIDTH-1:0]      out_new_vel_x,
  output logic signed [DATA_WIDTH-1:0]      out_new_vel_y,
  output logic signed [DATA_WIDTH-1:0]      out_new_vel_z
);

  import bpp_pkg::*;

  // position, vm and ef ride along with the cross product units
  localparam int CARRY_W = 8 * DATA_WIDTH;
  localparam logic [DATA_WIDTH-2:0] STEP_ONE = (DATA_WIDTH-1)'(64'd1 << FRAC_BITS);

  logic signed [ROT_W-1:0]      rot_r   [3];
  logic signed [ROT_W-1:0]      shear_r [3];
  logic signed [DATA_WIDTH-1:0] kick_r;
  logic [DATA_WIDTH-2:0]        step_r;

  logic signed [DATA_WIDTH-1:0] in_pos   [2];
  logic signed [DATA_WIDTH-1:0] in_vel   [3];
  logic signed [DATA_WIDTH-1:0] in_field [2];

  logic                         k_ready;
  logic                         k_valid;
  logic signed [DATA_WIDTH-1:0] k_pos [2];
  logic signed [DATA_WIDTH-1:0] k_vm  [3];
  logic signed [DATA_WIDTH-1:0] k_ef  [3];
  logic [CARRY_W-1:0]           k_carry;
  logic signed [DATA_WIDTH-1:0] zero_vec [3];

  logic                         c1_ready;
  logic                         c1_valid;
  logic signed [DATA_WIDTH-1:0] c1_w [3];
  logic [CARRY_W-1:0]           c1_carry;
  logic signed [DATA_WIDTH-1:0] c1_vm [3];
  logic signed [DATA_WIDTH-1:0] c1_ef [3];

  logic                         c2_ready;
  logic                         c2_valid;
  logic signed [DATA_WIDTH-1:0] c2_nv [3];
  logic [CARRY_W-1:0]           c2_carry;
  logic signed [DATA_WIDTH-1:0] c2_pos [2];

  logic                         a_ready;
  logic                         a_valid;
  logic signed [DATA_WIDTH-1:0] a_pos [2];
  logic signed [DATA_WIDTH-1:0] a_vel [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r   <= '{default: '0};
      shear_r <= '{default: '0};
      kick_r  <= '0;
      step_r  <= STEP_ONE;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_ROT_X:      rot_r[0]   <= cfg_wdata[ROT_W-1:0];
        REG_ROT_Y:      rot_r[1]   <= cfg_wdata[ROT_W-1:0];
        REG_ROT_Z:      rot_r[2]   <= cfg_wdata[ROT_W-1:0];
        REG_SHEAR_X:    shear_r[0] <= cfg_wdata[ROT_W-1:0];
        REG_SHEAR_Y:    shear_r[1] <= cfg_wdata[ROT_W-1:0];
        REG_SHEAR_Z:    shear_r[2] <= cfg_wdata[ROT_W-1:0];
        REG_KICK_SCALE: kick_r     <= cfg_wdata[DATA_WIDTH-1:0];
        REG_TIME_STEP:  step_r     <= cfg_wdata[DATA_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  assign in_pos   = '{in_pos_x, in_pos_y};
  assign in_vel   = '{in_vel_x, in_vel_y, in_vel_z};
  assign in_field = '{in_field_x, in_field_y};
  assign zero_vec = '{default: '0};

  assign in_stall = !k_ready;

  bpp_kick #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_kick (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (k_ready),
    .pos_i    (in_pos),
    .vel_i    (in_vel),
    .field_i  (in_field),
    .kick_i   (kick_r),
    .dn_valid (k_valid),
    .dn_ready (c1_ready),
    .pos_o    (k_pos),
    .vm_o     (k_vm),
    .ef_o     (k_ef)
  );

  assign k_carry = {k_pos[0], k_pos[1], k_vm[0], k_vm[1], k_vm[2], k_ef[0], k_ef[1], k_ef[2]};

  // first rotation: w = vm + vm x T
  bpp_cross #(
    .DATA_WIDTH (DATA_WIDTH),
    .CARRY_W    (CARRY_W)
  ) u_cross_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (k_valid),
    .up_ready (c1_ready),
    .a_i      (k_vm),
    .b_i      (rot_r),
    .base_i   (k_vm),
    .extra_i  (zero_vec),
    .carry_i  (k_carry),
    .dn_valid (c1_valid),
    .dn_ready (c2_ready),
    .res_o    (c1_w),
    .carry_o  (c1_carry)
  );

  assign c1_vm[0] = c1_carry[5*DATA_WIDTH +: DATA_WIDTH];
  assign c1_vm[1] = c1_carry[4*DATA_WIDTH +: DATA_WIDTH];
  assign c1_vm[2] = c1_carry[3*DATA_WIDTH +: DATA_WIDTH];
  assign c1_ef[0] = c1_carry[2*DATA_WIDTH +: DATA_WIDTH];
  assign c1_ef[1] = c1_carry[1*DATA_WIDTH +: DATA_WIDTH];
  assign c1_ef[2] = c1_carry[0 +: DATA_WIDTH];

  // second rotation: v' = vm + w x s + ef
  bpp_cross #(
    .DATA_WIDTH (DATA_WIDTH),
    .CARRY_W    (CARRY_W)
  ) u_cross_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c1_valid),
    .up_ready (c2_ready),
    .a_i      (c1_w),
    .b_i      (shear_r),
    .base_i   (c1_vm),
    .extra_i  (c1_ef),
    .carry_i  (c1_carry),
    .dn_valid (c2_valid),
    .dn_ready (a_ready),
    .res_o    (c2_nv),
    .carry_o  (c2_carry)
  );

  assign c2_pos[0] = c2_carry[7*DATA_WIDTH +: DATA_WIDTH];
  assign c2_pos[1] = c2_carry[6*DATA_WIDTH +: DATA_WIDTH];

  bpp_advance #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_advance (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c2_valid),
    .up_ready (a_ready),
    .pos_i    (c2_pos),
    .vel_i    (c2_nv),
    .step_i   (step_r),
    .dn_valid (a_valid),
    .dn_ready (!out_stall),
    .pos_o    (a_pos),
    .vel_o    (a_vel)
  );

  assign out_valid     = a_valid;
  assign out_new_pos_x = a_pos[0];
  assign out_new_pos_y = a_pos[1];
  assign out_new_vel_x = a_vel[0];
  assign out_new_vel_y = a_vel[1];
  assign out_new_vel_z = a_vel[2];

endmodule
